// ===== hw/rtl/efr_pkg.sv =====
// efr_pkg: shared types and constants of the escaped frame receiver
// used by efr_frame, efr_rsp_fifo, the top level and its checker
// no dependencies

package efr_pkg;

   typedef enum logic [2:0] {
      KIND_DATA     = 3'd0,
      KIND_ACCEPTED = 3'd1,
      KIND_BAD_SUM  = 3'd2,
      KIND_BAD_LEN  = 3'd3,
      KIND_BAD_ESC  = 3'd4,
      KIND_DISCARD  = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  delim;
      logic [7:0]  esc;
      logic [7:0]  esc_delim_code;
      logic [7:0]  esc_esc_code;
   } cfg_type;

   // results produced by one item, slot0 first
   typedef struct packed {
      logic [1:0]  cnt;
      rsp_type     slot0;
      rsp_type     slot1;
   } push_type;

   localparam logic [7:0] CSR_DELIM          = 8'd0;
   localparam logic [7:0] CSR_ESC            = 8'd1;
   localparam logic [7:0] CSR_ESC_DELIM_CODE = 8'd2;
   localparam logic [7:0] CSR_ESC_ESC_CODE   = 8'd3;

   localparam logic [7:0] DELIM_RESET          = 8'd126;
   localparam logic [7:0] ESC_RESET            = 8'd127;
   localparam logic [7:0] ESC_DELIM_CODE_RESET = 8'd1;
   localparam logic [7:0] ESC_ESC_CODE_RESET   = 8'd2;

   localparam logic [7:0] CHECK_TARGET = 8'h55;
   localparam int         MIN_RAW      = 3;
   localparam int         RSP_DEPTH    = 4;

endpackage

// ===== hw/rtl/efr_frame.sv =====
// efr_frame: frame state and per-byte decode of the escaped frame receiver
// produces up to two results per item as an efr_pkg::push_type
// depends on efr_pkg

module efr_frame #(
   parameter int FRAME_BUF_SIZE = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        rx_byte,
   input  efr_pkg::cfg_type  cfg,
   output efr_pkg::push_type push
);

   localparam int RAW_W = $clog2(FRAME_BUF_SIZE);

   logic             in_frame_ff, in_frame_in;
   logic [RAW_W-1:0] raw_ff, raw_in;
   logic [7:0]       dcnt_ff, dcnt_in;
   logic [7:0]       sum_ff, sum_in;
   logic             pend_ff, pend_in;
   logic [7:0]       first_ff, first_in;
   logic             err_ff, err_in;

   logic             is_delim;
   logic [RAW_W:0]   raw_next;
   logic             overflow;
   logic             emit_vld;
   logic [7:0]       emit_val;
   logic [7:0]       dcnt_after;
   logic [7:0]       sum_after;
   logic [7:0]       first_after;
   logic             stat_vld;
   efr_pkg::kind_type stat_kind;
   efr_pkg::rsp_type  emit_rsp, stat_rsp;
   logic             do_clear;

   assign is_delim = (rx_byte == cfg.delim);
   assign raw_next = {1'b0, raw_ff} + (RAW_W+1)'(1);
   assign overflow = (raw_next >= (RAW_W+1)'(FRAME_BUF_SIZE));

   always_comb begin
      emit_vld = 1'b0;
      emit_val = rx_byte;
      pend_in  = pend_ff;
      err_in   = err_ff;
      if (in_frame_ff) begin
         if (is_delim) begin
            emit_vld = pend_ff && !err_ff;
            emit_val = cfg.esc;
            pend_in  = 1'b0;
         end else if (!err_ff) begin
            if (pend_ff) begin
               pend_in = 1'b0;
               if (rx_byte == cfg.esc_delim_code) begin
                  emit_vld = 1'b1;
                  emit_val = cfg.delim;
               end else if (rx_byte == cfg.esc_esc_code) begin
                  emit_vld = 1'b1;
                  emit_val = cfg.esc;
               end else begin
                  err_in = 1'b1;
               end
            end else if (rx_byte == cfg.esc) begin
               pend_in = 1'b1;
            end else begin
               emit_vld = 1'b1;
            end
         end
      end
   end

   assign dcnt_after  = dcnt_ff + 8'(emit_vld);
   assign sum_after   = emit_vld ? sum_ff + emit_val : sum_ff;
   assign first_after = (emit_vld && dcnt_ff == 8'd0) ? emit_val : first_ff;

   always_comb begin
      stat_vld = in_frame_ff && (is_delim || overflow);
      if (!is_delim || raw_ff < RAW_W'(efr_pkg::MIN_RAW)) begin
         stat_kind = efr_pkg::KIND_DISCARD;
      end else if (err_ff) begin
         stat_kind = efr_pkg::KIND_BAD_ESC;
      end else if (sum_after != efr_pkg::CHECK_TARGET) begin
         stat_kind = efr_pkg::KIND_BAD_SUM;
      end else if (({1'b0, dcnt_after} - 9'd2) != {1'b0, first_after}) begin
         stat_kind = efr_pkg::KIND_BAD_LEN;
      end else begin
         stat_kind = efr_pkg::KIND_ACCEPTED;
      end
   end

   always_comb begin
      emit_rsp.kind       = efr_pkg::KIND_DATA;
      emit_rsp.data_byte  = emit_val;
      emit_rsp.byte_index = dcnt_ff;
      emit_rsp.last       = !stat_vld;
      stat_rsp.kind       = stat_kind;
      stat_rsp.data_byte  = 8'd0;
      stat_rsp.byte_index = dcnt_after;
      stat_rsp.last       = 1'b1;
      push.cnt   = fire ? 2'(emit_vld) + 2'(stat_vld) : 2'd0;
      push.slot0 = emit_vld ? emit_rsp : stat_rsp;
      push.slot1 = stat_rsp;
   end

   always_comb begin
      do_clear    = 1'b0;
      in_frame_in = in_frame_ff;
      raw_in      = raw_ff;
      if (!in_frame_ff) begin
         if (is_delim) begin
            in_frame_in = 1'b1;
            do_clear    = 1'b1;
         end
      end else if (is_delim) begin
         do_clear = 1'b1;
         if (raw_ff >= RAW_W'(efr_pkg::MIN_RAW)) begin
            in_frame_in = 1'b0;
         end
      end else if (overflow) begin
         do_clear = 1'b1;
      end else begin
         raw_in = raw_next[RAW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         raw_ff      <= '0;
         dcnt_ff     <= 8'd0;
         sum_ff      <= 8'd0;
         pend_ff     <= 1'b0;
         first_ff    <= 8'd0;
         err_ff      <= 1'b0;
      end else if (fire) begin
         in_frame_ff <= in_frame_in;
         if (do_clear) begin
            raw_ff   <= '0;
            dcnt_ff  <= 8'd0;
            sum_ff   <= 8'd0;
            pend_ff  <= 1'b0;
            first_ff <= 8'd0;
            err_ff   <= 1'b0;
         end else begin
            raw_ff   <= raw_in;
            dcnt_ff  <= dcnt_after;
            sum_ff   <= sum_after;
            pend_ff  <= pend_in;
            first_ff <= first_after;
            err_ff   <= err_in;
         end
      end
   end

endmodule

// ===== hw/rtl/efr_rsp_fifo.sv =====
// efr_rsp_fifo: result queue that takes up to two results per cycle
// and hands out one per cycle while out_ready is high, on a valid/ready channel
// depends on efr_pkg

module efr_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  efr_pkg::push_type push,
   output logic              has_room,
   output logic              out_valid,
   input  logic              out_ready,
   output efr_pkg::rsp_type  out_rsp
);

   localparam int PTR_W = $clog2(efr_pkg::RSP_DEPTH);
   localparam int CNT_W = $clog2(efr_pkg::RSP_DEPTH + 1);

   efr_pkg::rsp_type mem [efr_pkg::RSP_DEPTH];

   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;

   assign out_valid = (cnt_ff != '0);
   assign out_rsp   = mem[rd_ff];
   assign pop       = out_valid && out_ready;
   assign has_room  = (cnt_ff <= CNT_W'(efr_pkg::RSP_DEPTH - 2));

   assign wr_in  = wr_ff + PTR_W'(push.cnt);
   assign rd_in  = rd_ff + PTR_W'(pop);
   assign cnt_in = cnt_ff + CNT_W'(push.cnt) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         mem[wr_ff] <= push.slot0;
      end
      if (push.cnt == 2'd2) begin
         mem[wr_ff + PTR_W'(1)] <= push.slot1;
      end
   end

endmodule

// ===== hw/rtl/escaped_frame_receiver_unit.sv =====
// escaped_frame_receiver_unit: top level of the byte-stuffed frame receiver
// holds the config registers and the input stage; uses efr_frame, efr_rsp_fifo
// depends on efr_pkg

// Each received byte goes through an input register, is decoded in one pass by
// efr_frame against the frame state, and its zero, one or two results go into a
// four-entry result queue that drains one item per cycle while rsp_ready is high.
// Since a byte may yield two results, the input stage holds while fewer than two
// queue entries are free; with one result per byte and rsp_ready high the rate
// stays at one byte per cycle. Config registers are written through csr_ (always
// ready) by the user only while idle; the block itself does not enforce it.

module escaped_frame_receiver_unit #(
   parameter int FRAME_BUF_SIZE = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_byte_index,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_index,
   input  logic [7:0] csr_wdata
);

   efr_pkg::cfg_type  cfg_ff, cfg_in;
   logic              stg_vld_ff, stg_vld_in;
   logic [7:0]        stg_byte_ff;
   logic              fire;
   logic              has_room;
   efr_pkg::push_type push;
   efr_pkg::rsp_type  out_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            efr_pkg::CSR_DELIM:          cfg_in.delim          = csr_wdata;
            efr_pkg::CSR_ESC:            cfg_in.esc            = csr_wdata;
            efr_pkg::CSR_ESC_DELIM_CODE: cfg_in.esc_delim_code = csr_wdata;
            efr_pkg::CSR_ESC_ESC_CODE:   cfg_in.esc_esc_code   = csr_wdata;
            default:                     cfg_in                = cfg_ff;
         endcase
      end
   end

   assign fire       = stg_vld_ff && has_room;
   assign req_ready  = !stg_vld_ff || fire;
   assign stg_vld_in = (req_valid && req_ready) ? 1'b1 : (fire ? 1'b0 : stg_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delim          <= efr_pkg::DELIM_RESET;
         cfg_ff.esc            <= efr_pkg::ESC_RESET;
         cfg_ff.esc_delim_code <= efr_pkg::ESC_DELIM_CODE_RESET;
         cfg_ff.esc_esc_code   <= efr_pkg::ESC_ESC_CODE_RESET;
         stg_vld_ff            <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         stg_vld_ff <= stg_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stg_byte_ff <= req_rx_byte;
      end
   end

   efr_frame #(
      .FRAME_BUF_SIZE (FRAME_BUF_SIZE)
   ) u_frame (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .rx_byte (stg_byte_ff),
      .cfg     (cfg_ff),
      .push    (push)
   );

   efr_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (out_rsp)
   );

   assign rsp_kind       = out_rsp.kind;
   assign rsp_data_byte  = out_rsp.data_byte;
   assign rsp_byte_index = out_rsp.byte_index;
   assign rsp_last       = out_rsp.last;

endmodule

// ===== hw/rtl/efr_checker.sv =====
// efr_checker: port-level assertions for escaped_frame_receiver_unit
// bound to the top level below; depends on efr_pkg

module efr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic [7:0] rsp_byte_index,
   input logic       rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_data_byte) && $stable(rsp_byte_index) && $stable(rsp_last))
      else $error("result item changed while stalled");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != efr_pkg::KIND_DATA |-> rsp_data_byte == 8'd0)
      else $error("status item with nonzero data byte");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != efr_pkg::KIND_DATA |-> rsp_last)
      else $error("status item not marked last");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind <= efr_pkg::KIND_DISCARD)
      else $error("result kind out of range");

endmodule

bind escaped_frame_receiver_unit efr_checker u_efr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind       (rsp_kind),
   .rsp_data_byte  (rsp_data_byte),
   .rsp_byte_index (rsp_byte_index),
   .rsp_last       (rsp_last)
);

// ===== tb/escaped_frame_receiver_unit_test.sv =====
// escaped_frame_receiver_unit_test: self-checking bench for the byte-stuffed frame receiver
// drives bytes and register writes, predicts each result and checks every one in order
// depends on efr_pkg and escaped_frame_receiver_unit
`timescale 1ns / 100ps

module escaped_frame_receiver_unit_test;
   import efr_pkg::*;

   localparam int CLK_PERIOD       = 8;
   localparam int RESET_CYCLES     = 7;
   localparam int FRAME_BUF_SIZE   = 256;
   localparam int RANDOM_PER_PHASE = 30;
   localparam int SETTLE_CYCLES    = 8;
   localparam int DRAIN_CYCLES     = 20;
   localparam int HOLD_CYCLES      = 200;
   localparam int IDLE_LIMIT       = 2000;
   localparam int MAX_PRINTED      = 20;
   localparam int NUM_ROWS         = 26;

   typedef struct packed {
      logic [7:0] rx;
      logic       chk;
      kind_type   kind;
      logic [7:0] idx;
   } dir_row_t;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_data_byte;
   logic [7:0] rsp_byte_index;
   logic       rsp_last;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_index;
   logic [7:0] csr_wdata;

   // status expected from the byte on req_, for the typed rows only
   logic       cur_chk;
   kind_type   cur_kind;
   logic [7:0] cur_idx;

   // model of the receiver
   cfg_type    cfg_model;
   logic       fr_open;
   logic [7:0] fr_raw;
   logic [7:0] fr_len;
   logic [7:0] fr_sum;
   logic       fr_esc_pend;
   logic [7:0] fr_first;
   logic       fr_esc_err;
   rsp_type    due_results[$];

   int unsigned error_count;
   int unsigned items_sent;
   int unsigned results_seen;
   int unsigned idle_cycles;
   int unsigned burst_left;
   int unsigned settings_used;
   int unsigned kind_seen [6];
   logic        hold_wanted;
   logic        hold_active;

   dir_row_t directed_rows [0:NUM_ROWS-1] = '{
      '{8'h00, 1'b0, KIND_DATA,     8'd0},
      '{8'h7E, 1'b0, KIND_DATA,     8'd0},
      '{8'h01, 1'b0, KIND_DATA,     8'd0},
      '{8'h00, 1'b0, KIND_DATA,     8'd0},
      '{8'h54, 1'b0, KIND_DATA,     8'd0},
      '{8'h7E, 1'b1, KIND_ACCEPTED, 8'd3},
      '{8'h7E, 1'b0, KIND_DATA,     8'd0},
      '{8'h7F, 1'b0, KIND_DATA,     8'd0},
      '{8'h01, 1'b0, KIND_DATA,     8'd0},
      '{8'h7F, 1'b0, KIND_DATA,     8'd0},
      '{8'h02, 1'b0, KIND_DATA,     8'd0},
      '{8'hFF, 1'b0, KIND_DATA,     8'd0},
      '{8'h7E, 1'b1, KIND_BAD_SUM,  8'd3},
      '{8'h7E, 1'b0, KIND_DATA,     8'd0},
      '{8'h05, 1'b0, KIND_DATA,     8'd0},
      '{8'h7F, 1'b0, KIND_DATA,     8'd0},
      '{8'h09, 1'b0, KIND_DATA,     8'd0},
      '{8'h7E, 1'b1, KIND_BAD_ESC,  8'd1},
      '{8'h7E, 1'b0, KIND_DATA,     8'd0},
      '{8'h7E, 1'b1, KIND_DISCARD,  8'd0},
      '{8'h7F, 1'b0, KIND_DATA,     8'd0},
      '{8'h7E, 1'b1, KIND_DISCARD,  8'd1},
      '{8'h00, 1'b0, KIND_DATA,     8'd0},
      '{8'h55, 1'b0, KIND_DATA,     8'd0},
      '{8'h00, 1'b0, KIND_DATA,     8'd0},
      '{8'h7E, 1'b1, KIND_BAD_LEN,  8'd3}
   };

   escaped_frame_receiver_unit #(
      .FRAME_BUF_SIZE(FRAME_BUF_SIZE)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_data_byte (rsp_data_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("tb: mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   function automatic void clear_frame_state();
      fr_raw      = 8'd0;
      fr_len      = 8'd0;
      fr_sum      = 8'd0;
      fr_esc_pend = 1'b0;
      fr_first    = 8'd0;
      fr_esc_err  = 1'b0;
   endfunction

   function automatic void push_result(input kind_type k, input logic [7:0] d,
                                       input logic [7:0] idx);
      rsp_type r;
      r.kind       = k;
      r.data_byte  = d;
      r.byte_index = idx;
      r.last       = 1'b0;
      due_results.push_back(r);
   endfunction

   function automatic void emit_decoded(input logic [7:0] b);
      if (fr_len == 8'd0) begin
         fr_first = b;
      end
      push_result(KIND_DATA, b, fr_len);
      fr_sum = fr_sum + b;
      fr_len = fr_len + 8'd1;
   endfunction

   // returns the number of results the byte causes, queued in due_results
   function automatic int unsigned decode_rx_byte(input logic [7:0] b);
      int unsigned n0;
      int unsigned raw_next;
      kind_type    k;
      rsp_type     r;
      n0 = due_results.size();
      if (!fr_open) begin
         if (b == cfg_model.delim) begin
            fr_open = 1'b1;
            clear_frame_state();
         end
         return 0;
      end
      if (b == cfg_model.delim) begin
         if (fr_esc_pend && !fr_esc_err) begin
            emit_decoded(cfg_model.esc);
         end
         fr_esc_pend = 1'b0;
         if (int'(fr_raw) >= MIN_RAW) begin
            if (fr_esc_err) begin
               k = KIND_BAD_ESC;
            end else if (fr_sum != CHECK_TARGET) begin
               k = KIND_BAD_SUM;
            end else if (int'(fr_len) - 2 != int'(fr_first)) begin
               k = KIND_BAD_LEN;
            end else begin
               k = KIND_ACCEPTED;
            end
            push_result(k, 8'd0, fr_len);
            fr_open = 1'b0;
         end else begin
            push_result(KIND_DISCARD, 8'd0, fr_len);
         end
         clear_frame_state();
      end else begin
         raw_next = int'(fr_raw) + 1;
         if (!fr_esc_err) begin
            if (fr_esc_pend) begin
               fr_esc_pend = 1'b0;
               if (b == cfg_model.esc_delim_code) begin
                  emit_decoded(cfg_model.delim);
               end else if (b == cfg_model.esc_esc_code) begin
                  emit_decoded(cfg_model.esc);
               end else begin
                  fr_esc_err = 1'b1;
               end
            end else if (b == cfg_model.esc) begin
               fr_esc_pend = 1'b1;
            end else begin
               emit_decoded(b);
            end
         end
         if (raw_next >= FRAME_BUF_SIZE) begin
            push_result(KIND_DISCARD, 8'd0, fr_len);
            clear_frame_state();
         end else begin
            fr_raw = raw_next[7:0];
         end
      end
      if (due_results.size() > n0) begin
         r = due_results.pop_back();
         r.last = 1'b1;
         due_results.push_back(r);
      end
      return due_results.size() - n0;
   endfunction

   always @(posedge clock) begin : monitor
      int unsigned n;
      rsp_type     want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            n = decode_rx_byte(req_rx_byte);
            if (cur_chk && (n == 0 || due_results[$].kind != cur_kind ||
                            due_results[$].byte_index != cur_idx)) begin
               report_error($sformatf("byte %02h should close with kind %0d length %0d",
                                      req_rx_byte, cur_kind, cur_idx));
            end
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (due_results.size() == 0) begin
               report_error($sformatf("result with nothing due: kind %0d index %0d",
                                      rsp_kind, rsp_byte_index));
            end else begin
               want = due_results.pop_front();
               kind_seen[int'(want.kind)]++;
               if (rsp_kind !== want.kind || rsp_data_byte !== want.data_byte ||
                   rsp_byte_index !== want.byte_index || rsp_last !== want.last) begin
                  report_error($sformatf(
                     "got kind %0d data %02h index %0d last %0b, want %0d %02h %0d %0b",
                     rsp_kind, rsp_data_byte, rsp_byte_index, rsp_last,
                     want.kind, want.data_byte, want.byte_index, want.last));
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("tb: no handshake for %0d cycles, %0d results still due",
               IDLE_LIMIT, due_results.size());
      $display("tb: failure");
      $finish;
   end

   initial begin : rsp_side
      int unsigned mode;
      int unsigned stretch;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            hold_active = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
         end
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(4, 40);
         repeat (stretch) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic chk = 1'b0,
                            input kind_type k = KIND_DATA, input logic [7:0] idx = 8'd0);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      cur_chk     <= chk;
      cur_kind    <= k;
      cur_idx     <= idx;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // stop sending and wait for the block to drain
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DELIM:          cfg_model.delim          = val;
         CSR_ESC:            cfg_model.esc            = val;
         CSR_ESC_DELIM_CODE: cfg_model.esc_delim_code = val;
         CSR_ESC_ESC_CODE:   cfg_model.esc_esc_code   = val;
         default: ;
      endcase
   endtask

   task automatic write_config(input cfg_type c);
      settle();
      write_reg(CSR_DELIM, c.delim);
      write_reg(CSR_ESC, c.esc);
      write_reg(CSR_ESC_DELIM_CODE, c.esc_delim_code);
      write_reg(CSR_ESC_ESC_CODE, c.esc_esc_code);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic send_decoded(input logic [7:0] b);
      if (b == cfg_model.delim) begin
         send_byte(cfg_model.esc);
         send_byte(cfg_model.esc_delim_code);
      end else if (b == cfg_model.esc) begin
         send_byte(cfg_model.esc);
         send_byte(cfg_model.esc_esc_code);
      end else begin
         send_byte(b);
      end
   endtask

   task automatic send_random_frame();
      logic [7:0]  body[$];
      logic [7:0]  sum;
      logic [7:0]  bad_code;
      int unsigned style;
      int unsigned len;
      int          bad_pos;
      int unsigned i;
      style   = $urandom_range(0, 9);
      bad_pos = -1;
      body.delete();
      if (style <= 4) begin
         // well-formed frame, valid unless corrupted below
         len = $urandom_range(3, 12);
         body.push_back(8'(len - 2));
         sum = 8'(len - 2);
         for (i = 1; i < len - 1; i++) begin
            body.push_back(8'($urandom));
            sum = sum + body[i];
         end
         body.push_back(CHECK_TARGET - sum);
         if (style == 3) begin
            i = $urandom_range(0, len - 1);
            body[i] = body[i] ^ (8'd1 << $urandom_range(0, 7));
         end else if (style == 4) begin
            body[0]       = body[0] + 8'd1;
            body[len - 1] = body[len - 1] - 8'd1;
         end
      end else if (style <= 7) begin
         len = $urandom_range(0, 12);
         for (i = 0; i < len; i++) body.push_back(8'($urandom));
         if (style == 6) begin
            bad_pos = $urandom_range(0, len);
            do bad_code = 8'($urandom);
            while (bad_code == cfg_model.esc_delim_code || bad_code == cfg_model.esc_esc_code ||
                   bad_code == cfg_model.delim);
         end
      end else begin
         // line noise outside any framing
         repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
         return;
      end
      send_byte(cfg_model.delim);
      for (i = 0; i <= body.size(); i++) begin
         if (int'(i) == bad_pos) begin
            send_byte(cfg_model.esc);
            send_byte(bad_code);
         end
         if (i < body.size()) begin
            send_decoded(body[i]);
         end
      end
      if (style == 7) begin
         send_byte(cfg_model.esc);
      end
      send_byte(cfg_model.delim);
   endtask

   task automatic run_random(input int unsigned quota);
      int unsigned start;
      start = items_sent;
      while (items_sent - start < quota) send_random_frame();
   endtask

   task automatic send_overlong_frame();
      logic [7:0] b;
      send_byte(cfg_model.delim);
      repeat (FRAME_BUF_SIZE + 4) begin
         b = 8'($urandom);
         if (b == cfg_model.delim) begin
            b = b ^ 8'h01;
         end
         send_byte(b);
      end
      send_byte(cfg_model.delim);
   endtask

   initial begin : stimulus
      int i;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= 8'd0;
      csr_valid   <= 1'b0;
      csr_index   <= 8'd0;
      csr_wdata   <= 8'd0;
      cur_chk     <= 1'b0;
      cur_kind    <= KIND_DATA;
      cur_idx     <= 8'd0;
      cfg_model   = '{DELIM_RESET, ESC_RESET, ESC_DELIM_CODE_RESET, ESC_ESC_CODE_RESET};
      fr_open     = 1'b0;
      clear_frame_state();
      error_count   = 0;
      items_sent    = 0;
      results_seen  = 0;
      idle_cycles   = 0;
      burst_left    = 0;
      settings_used = 1;
      hold_wanted   = 1'b0;
      hold_active   = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < NUM_ROWS; i++) begin
         send_byte(directed_rows[i].rx, directed_rows[i].chk,
                   directed_rows[i].kind, directed_rows[i].idx);
      end

      write_config('{8'h00, 8'hFF, 8'h00, 8'hFF});
      run_random(RANDOM_PER_PHASE);

      // equal codes, and a long receiver stall while bytes keep coming
      write_config('{8'hFF, 8'h00, 8'h01, 8'h01});
      hold_wanted = 1'b1;
      wait (hold_active);
      run_random(RANDOM_PER_PHASE);

      // delimiter equal to the escape byte
      write_config('{8'h55, 8'h55, 8'hAA, 8'h55});
      run_random(RANDOM_PER_PHASE);

      write_config('{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)});
      run_random(RANDOM_PER_PHASE);

      write_config('{DELIM_RESET, ESC_RESET, ESC_DELIM_CODE_RESET, ESC_ESC_CODE_RESET});
      run_random(RANDOM_PER_PHASE / 2);
      send_overlong_frame();
      run_random(RANDOM_PER_PHASE / 2);

      req_valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (due_results.size() != 0) begin
         report_error($sformatf("%0d results never arrived", due_results.size()));
      end

      $display("tb: %0d bytes over %0d register settings, %0d results checked, %0d errors",
               items_sent, settings_used, results_seen, error_count);
      $display("tb: statuses: accepted %0d, bad sum %0d, bad length %0d, bad escape %0d, %s %0d",
               kind_seen[KIND_ACCEPTED], kind_seen[KIND_BAD_SUM], kind_seen[KIND_BAD_LEN],
               kind_seen[KIND_BAD_ESC], "discarded", kind_seen[KIND_DISCARD]);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
